// File: rtl/ipid_pkg.sv
// Shared constants and types for the incremental PID unit.
`default_nettype none

package ipid_pkg;

    localparam int FRAC_SCALE_DEF = 1000;

    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 16;
    localparam int CTRL_W  = 32;
    localparam int WIDE_W  = 64;
    localparam int REM_W   = 17;
    localparam int INDEX_W = 2;

    // Iteration counts of the shared unit.
    localparam int MUL_STEPS      = 16;
    localparam int DIV_STEPS      = 32;
    localparam int DIV_WIDE_STEPS = 64;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 16'd1000;
    localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 16'd0;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST    = 16'd0;
    localparam logic [GAIN_W-1:0] SAMPLE_PERIOD_RST = 16'd1000;

    localparam logic [INDEX_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [INDEX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
    localparam logic [INDEX_W-1:0] REG_DERIV_GAIN    = 2'd2;
    localparam logic [INDEX_W-1:0] REG_SAMPLE_PERIOD = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MUL,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
        logic      wide;
    } arith_req_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integral_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] sample_period;
    } pid_cfg_t;

endpackage

`default_nettype wire

// File: rtl/incremental_pid_fixed_point_unit.sv
// Top level of the incremental (velocity-form) fixed-point PID unit.
`default_nettype none

// Each accepted error beat produces one saturated control beat. The work is
// done by a single shared arithmetic unit stepped through 44 operations: 17
// shift-add multiplies of 16 steps, 10 divides of 32 steps, 3 divides of 64
// steps and 14 adds. Each operation is issued, run and written back in turn,
// then the sum is saturated in C_SAT and handed over in C_OUT. s_axis_tready
// stays low from the acceptance of a sample until its result is handed
// over, so a new sample is taken only once the last one is through. The
// result sits in an output register, so a new sample can be taken while it
// waits on m_axis_tready; a further result waits until that register is
// free, which holds s_axis_tready low longer. Registers are written through
// cfg_wr_en/cfg_index/cfg_wr_data: 0 proportional gain, 1 integral gain,
// 2 derivative gain, 3 sample period, all in units of 1/FRAC_SCALE. The
// user must write them only while the unit is idle; the block does not
// enforce it.
module incremental_pid_fixed_point_unit #(
    parameter int FRAC_SCALE = ipid_pkg::FRAC_SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // [15:0] error_sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // [31:0] control_value
    input  logic                               cfg_wr_en,
    input  logic [ipid_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [ipid_pkg::GAIN_W-1:0]        cfg_wr_data
);
    import ipid_pkg::*;

    pid_cfg_t cfg_reg;

    logic                     out_valid_reg;
    logic [CTRL_W-1:0]        out_data_reg;
    logic                     out_free;
    logic                     res_valid;
    logic signed [CTRL_W-1:0] res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain     <= PROP_GAIN_RST;
            cfg_reg.integral_gain <= INTEGRAL_GAIN_RST;
            cfg_reg.deriv_gain    <= DERIV_GAIN_RST;
            cfg_reg.sample_period <= SAMPLE_PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_wr_data;
                REG_INTEGRAL_GAIN: cfg_reg.integral_gain <= cfg_wr_data;
                REG_DERIV_GAIN:    cfg_reg.deriv_gain    <= cfg_wr_data;
                REG_SAMPLE_PERIOD: cfg_reg.sample_period <= cfg_wr_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    ipid_ctrl #(
        .FRAC_SCALE (FRAC_SCALE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .error_sample (s_axis_tdata),
        .cfg          (cfg_reg),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res_data     (res_data)
    );

    // The output register is free when empty or when its beat leaves now.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/ipid_arith.sv
// Shared iterative arithmetic unit: add, shift-add multiply, restoring divide.
`default_nettype none

module ipid_arith (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ipid_pkg::arith_req_t                req,
    input  logic signed [ipid_pkg::WIDE_W-1:0]  opa,
    input  logic signed [ipid_pkg::WIDE_W-1:0]  opb,
    output logic                                done,
    output logic signed [ipid_pkg::WIDE_W-1:0]  quo,
    output logic signed [ipid_pkg::REM_W-1:0]   rem
);
    import ipid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } state_t;

    state_t    state_reg, state_next;
    arith_op_t op_reg, op_next;
    logic      done_reg, done_next;
    logic [5:0] cnt_reg, cnt_next;

    logic              neg_reg, neg_next;
    logic [WIDE_W-1:0] acc_reg, acc_next;
    logic [WIDE_W-1:0] sh_reg, sh_next;
    logic [15:0]       mb_reg, mb_next;
    logic [15:0]       dv_reg, dv_next;
    logic [15:0]       part_reg, part_next;
    logic signed [WIDE_W-1:0] quo_reg, quo_next;
    logic signed [REM_W-1:0]  rem_reg, rem_next;

    logic [WIDE_W-1:0] mag_a;
    logic [WIDE_W-1:0] mag_b;
    logic [17:0]       trial;
    logic [WIDE_W-1:0] fix_val;

    assign mag_a = opa[WIDE_W-1] ? WIDE_W'(-opa) : WIDE_W'(opa);
    assign mag_b = opb[WIDE_W-1] ? WIDE_W'(-opb) : WIDE_W'(opb);

    // One restoring step: the partial remainder takes the next dividend bit.
    assign trial   = {1'b0, part_reg, sh_reg[WIDE_W-1]} - {2'b00, dv_reg};
    assign fix_val = (op_reg == OP_DIV) ? sh_reg : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        mb_next    = mb_reg;
        dv_next    = dv_reg;
        part_next  = part_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    op_next = req.op;
                    unique case (req.op)
                        OP_ADD:
                        begin
                            acc_next   = WIDE_W'(opa + opb);
                            neg_next   = 1'b0;
                            state_next = S_FIX;
                        end
                        OP_MUL:
                        begin
                            acc_next   = '0;
                            sh_next    = mag_a;
                            mb_next    = mag_b[15:0];
                            neg_next   = opa[WIDE_W-1] ^ opb[WIDE_W-1];
                            cnt_next   = 6'(MUL_STEPS - 1);
                            state_next = S_RUN;
                        end
                        OP_DIV:
                        begin
                            // A short dividend sits in the upper half so that only
                            // its significant bits are walked through.
                            sh_next    = req.wide ? mag_a : {mag_a[31:0], 32'd0};
                            part_next  = '0;
                            dv_next    = opb[15:0];
                            neg_next   = opa[WIDE_W-1];
                            cnt_next   = req.wide ? 6'(DIV_WIDE_STEPS - 1)
                                                  : 6'(DIV_STEPS - 1);
                            state_next = S_RUN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (op_reg == OP_MUL)
                begin
                    if (mb_reg[0])
                    begin
                        acc_next = acc_reg + sh_reg;
                    end
                    sh_next = {sh_reg[WIDE_W-2:0], 1'b0};
                    mb_next = {1'b0, mb_reg[15:1]};
                end
                else
                begin
                    if (!trial[17])
                    begin
                        part_next = trial[15:0];
                        sh_next   = {sh_reg[WIDE_W-2:0], 1'b1};
                    end
                    else
                    begin
                        part_next = {part_reg[14:0], sh_reg[WIDE_W-1]};
                        sh_next   = {sh_reg[WIDE_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                // Quotient truncates toward zero; the remainder keeps the
                // dividend's sign.
                quo_next   = neg_reg ? -$signed(fix_val) : $signed(fix_val);
                rem_next   = neg_reg ? -$signed({1'b0, part_reg})
                                     : $signed({1'b0, part_reg});
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ADD;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        sh_reg   <= sh_next;
        mb_reg   <= mb_next;
        dv_reg   <= dv_next;
        part_reg <= part_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/ipid_ctrl.sv
// Sequencer that runs the PID increment through the shared arithmetic unit.
`default_nettype none

module ipid_ctrl #(
    parameter int FRAC_SCALE = ipid_pkg::FRAC_SCALE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ipid_pkg::ERR_W-1:0]   error_sample,
    input  ipid_pkg::pid_cfg_t                  cfg,
    input  logic                                out_free,
    output logic                                res_valid,
    output logic signed [ipid_pkg::CTRL_W-1:0]  res_data
);
    import ipid_pkg::*;

    localparam logic signed [WIDE_W-1:0] SCALE_W  = WIDE_W'(FRAC_SCALE);
    localparam logic signed [WIDE_W-1:0] CTRL_MAX = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] CTRL_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        C_IDLE,
        C_ISSUE,
        C_WAIT,
        C_SAT,
        C_OUT
    } ctl_state_t;

    typedef enum logic [5:0] {
        ST_KP_DIV, ST_KI_DIV, ST_KD_DIV, ST_T_DIV, ST_E_DIV, ST_D2_DIV,
        ST_PW_MUL, ST_PW_DIV, ST_PF_MUL, ST_PF_DIV, ST_PF_ADD,
        ST_IA_MUL, ST_IB_MUL, ST_IB2_MUL, ST_IB2_ADD, ST_IB3_MUL, ST_IB3_DIV,
        ST_IB3_ADD, ST_IW_MUL, ST_IF_MUL, ST_IF2_MUL, ST_IF2_ADD, ST_IF3_MUL,
        ST_IF3_DIV, ST_IF3_ADD,
        ST_DA_MUL, ST_NUM_MUL, ST_DB1_MUL, ST_DB1_ADD, ST_DB2_MUL, ST_DB2_ADD,
        ST_DB3_MUL, ST_DB3_DIV, ST_DB3_ADD, ST_NS_MUL, ST_Q_DIV, ST_DQ_DIV,
        ST_W1_ADD, ST_W2_ADD, ST_W_MUL, ST_LC_ADD, ST_PF_SUM, ST_IF_SUM,
        ST_DF_SUM
    } step_t;

    ctl_state_t state_reg, state_next;
    step_t      step_reg, step_next;

    logic signed [ERR_W-1:0]  prev_error_reg, prev_error_next;
    logic signed [ERR_W-1:0]  prev_prev_error_reg, prev_prev_error_next;
    logic signed [CTRL_W-1:0] last_control_reg, last_control_next;

    // Working registers for one sample.
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [16:0]       d1_reg;
    logic signed [17:0]       d2_reg;
    logic [GAIN_W-1:0]        kp_w_reg, kp_f_reg, ki_w_reg, ki_f_reg;
    logic [GAIN_W-1:0]        kd_w_reg, kd_f_reg, t_w_reg, t_f_reg;
    logic signed [15:0]       eq_reg, er_reg;
    logic signed [17:0]       d2q_reg, d2r_reg;
    logic signed [WIDE_W-1:0] p_w_reg, p_f_reg, ia_reg, ib_reg, i_w_reg, i_f_reg;
    logic signed [WIDE_W-1:0] num_reg, d_w_reg, t0_reg, t1_reg;
    logic signed [REM_W-1:0]  d_f_reg;

    arith_req_t               req;
    arith_op_t                op;
    logic                     wide;
    logic signed [WIDE_W-1:0] opa, opb;
    logic                     u_done;
    logic signed [WIDE_W-1:0] u_quo;
    logic signed [REM_W-1:0]  u_rem;
    logic                     accept;
    logic                     period_zero;

    assign accept      = (state_reg == C_IDLE) && in_valid;
    assign period_zero = (cfg.sample_period == '0);

    // Operation and operands of the current step. Multiplier operand b is
    // always the one below 2^16 in magnitude.
    always_comb
    begin
        op   = OP_ADD;
        wide = 1'b0;
        opa  = '0;
        opb  = '0;
        unique case (step_reg)
            ST_KP_DIV:  begin op = OP_DIV; opa = WIDE_W'(cfg.prop_gain);     opb = SCALE_W; end
            ST_KI_DIV:  begin op = OP_DIV; opa = WIDE_W'(cfg.integral_gain); opb = SCALE_W; end
            ST_KD_DIV:  begin op = OP_DIV; opa = WIDE_W'(cfg.deriv_gain);    opb = SCALE_W; end
            ST_T_DIV:   begin op = OP_DIV; opa = WIDE_W'(cfg.sample_period); opb = SCALE_W; end
            ST_E_DIV:   begin op = OP_DIV; opa = WIDE_W'(e_reg);             opb = SCALE_W; end
            ST_D2_DIV:  begin op = OP_DIV; opa = WIDE_W'(d2_reg);            opb = SCALE_W; end
            ST_PW_MUL:  begin op = OP_MUL; opa = WIDE_W'(d1_reg); opb = WIDE_W'(kp_w_reg); end
            ST_PW_DIV:  begin op = OP_DIV; opa = t0_reg;          opb = SCALE_W; end
            ST_PF_MUL:  begin op = OP_MUL; opa = WIDE_W'(d1_reg); opb = WIDE_W'(kp_f_reg); end
            ST_PF_DIV:  begin op = OP_DIV; opa = t0_reg;          opb = SCALE_W; end
            ST_PF_ADD:  begin opa = p_f_reg; opb = t1_reg; end
            ST_IA_MUL:  begin op = OP_MUL; opa = WIDE_W'(t_w_reg); opb = WIDE_W'(ki_w_reg); end
            ST_IB_MUL:  begin op = OP_MUL; opa = WIDE_W'(t_f_reg); opb = WIDE_W'(ki_w_reg); end
            ST_IB2_MUL: begin op = OP_MUL; opa = WIDE_W'(t_w_reg); opb = WIDE_W'(ki_f_reg); end
            ST_IB2_ADD: begin opa = ib_reg; opb = t0_reg; end
            ST_IB3_MUL: begin op = OP_MUL; opa = WIDE_W'(t_f_reg); opb = WIDE_W'(ki_f_reg); end
            ST_IB3_DIV: begin op = OP_DIV; opa = t0_reg; opb = SCALE_W; end
            ST_IB3_ADD: begin opa = ib_reg; opb = t1_reg; end
            ST_IW_MUL:  begin op = OP_MUL; opa = ia_reg; opb = WIDE_W'(eq_reg); end
            ST_IF_MUL:  begin op = OP_MUL; opa = ia_reg; opb = WIDE_W'(er_reg); end
            ST_IF2_MUL: begin op = OP_MUL; opa = ib_reg; opb = WIDE_W'(eq_reg); end
            ST_IF2_ADD: begin opa = i_f_reg; opb = t0_reg; end
            ST_IF3_MUL: begin op = OP_MUL; opa = ib_reg; opb = WIDE_W'(er_reg); end
            ST_IF3_DIV: begin op = OP_DIV; wide = 1'b1; opa = t0_reg; opb = SCALE_W; end
            ST_IF3_ADD: begin opa = i_f_reg; opb = t1_reg; end
            ST_DA_MUL:  begin op = OP_MUL; opa = WIDE_W'(d2q_reg); opb = WIDE_W'(kd_w_reg); end
            ST_NUM_MUL: begin op = OP_MUL; opa = num_reg; opb = SCALE_W; end
            ST_DB1_MUL: begin op = OP_MUL; opa = WIDE_W'(d2r_reg); opb = WIDE_W'(kd_w_reg); end
            ST_DB1_ADD: begin opa = num_reg; opb = t0_reg; end
            ST_DB2_MUL: begin op = OP_MUL; opa = WIDE_W'(d2q_reg); opb = WIDE_W'(kd_f_reg); end
            ST_DB2_ADD: begin opa = num_reg; opb = t0_reg; end
            ST_DB3_MUL: begin op = OP_MUL; opa = WIDE_W'(d2r_reg); opb = WIDE_W'(kd_f_reg); end
            ST_DB3_DIV: begin op = OP_DIV; opa = t0_reg; opb = SCALE_W; end
            ST_DB3_ADD: begin opa = num_reg; opb = t1_reg; end
            ST_NS_MUL:  begin op = OP_MUL; opa = num_reg; opb = SCALE_W; end
            ST_Q_DIV:
            begin
                // A zero period forces a zero derivative term: 0 / 1.
                op   = OP_DIV;
                wide = 1'b1;
                opa  = period_zero ? '0 : t0_reg;
                opb  = period_zero ? WIDE_W'(1) : WIDE_W'(cfg.sample_period);
            end
            ST_DQ_DIV:  begin op = OP_DIV; wide = 1'b1; opa = t1_reg; opb = SCALE_W; end
            ST_W1_ADD:  begin opa = p_w_reg; opb = i_w_reg; end
            ST_W2_ADD:  begin opa = t0_reg;  opb = d_w_reg; end
            ST_W_MUL:   begin op = OP_MUL; opa = t0_reg; opb = SCALE_W; end
            ST_LC_ADD:  begin opa = t0_reg; opb = WIDE_W'(last_control_reg); end
            ST_PF_SUM:  begin opa = t0_reg; opb = p_f_reg; end
            ST_IF_SUM:  begin opa = t0_reg; opb = i_f_reg; end
            ST_DF_SUM:  begin opa = t0_reg; opb = WIDE_W'(d_f_reg); end
            default:    begin opa = '0; opb = '0; end
        endcase
    end

    always_comb
    begin
        req.start = (state_reg == C_ISSUE);
        req.op    = op;
        req.wide  = wide;
    end

    ipid_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .opa   (opa),
        .opb   (opb),
        .done  (u_done),
        .quo   (u_quo),
        .rem   (u_rem)
    );

    always_comb
    begin
        state_next           = state_reg;
        step_next            = step_reg;
        prev_error_next      = prev_error_reg;
        prev_prev_error_next = prev_prev_error_reg;
        last_control_next    = last_control_reg;
        res_valid            = 1'b0;

        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    step_next  = ST_KP_DIV;
                    state_next = C_ISSUE;
                end
            end
            C_ISSUE:
            begin
                state_next = C_WAIT;
            end
            C_WAIT:
            begin
                if (u_done)
                begin
                    if (step_reg == ST_DF_SUM)
                    begin
                        state_next = C_SAT;
                    end
                    else
                    begin
                        step_next  = step_t'(step_reg + 6'd1);
                        state_next = C_ISSUE;
                    end
                end
            end
            C_SAT:
            begin
                priority if (t0_reg > CTRL_MAX)
                begin
                    last_control_next = CTRL_MAX[CTRL_W-1:0];
                end
                else if (t0_reg < CTRL_MIN)
                begin
                    last_control_next = CTRL_MIN[CTRL_W-1:0];
                end
                else
                begin
                    last_control_next = t0_reg[CTRL_W-1:0];
                end
                prev_prev_error_next = prev_error_reg;
                prev_error_next      = e_reg;
                state_next           = C_OUT;
            end
            C_OUT:
            begin
                res_valid = out_free;
                if (out_free)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= C_IDLE;
            step_reg            <= ST_KP_DIV;
            prev_error_reg      <= '0;
            prev_prev_error_reg <= '0;
            last_control_reg    <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            step_reg            <= step_next;
            prev_error_reg      <= prev_error_next;
            prev_prev_error_reg <= prev_prev_error_next;
            last_control_reg    <= last_control_next;
        end
    end

    // Sample capture and write-back of the unit's results.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg  <= error_sample;
            d1_reg <= 17'(error_sample) - 17'(prev_error_reg);
            d2_reg <= 18'(error_sample) - (18'(prev_error_reg) <<< 1)
                      + 18'(prev_prev_error_reg);
        end
        if ((state_reg == C_WAIT) && u_done)
        begin
            unique case (step_reg)
                ST_KP_DIV: begin kp_w_reg <= u_quo[15:0]; kp_f_reg <= u_rem[15:0]; end
                ST_KI_DIV: begin ki_w_reg <= u_quo[15:0]; ki_f_reg <= u_rem[15:0]; end
                ST_KD_DIV: begin kd_w_reg <= u_quo[15:0]; kd_f_reg <= u_rem[15:0]; end
                ST_T_DIV:  begin t_w_reg  <= u_quo[15:0]; t_f_reg  <= u_rem[15:0]; end
                ST_E_DIV:  begin eq_reg   <= u_quo[15:0]; er_reg   <= u_rem[15:0]; end
                ST_D2_DIV: begin d2q_reg  <= u_quo[17:0]; d2r_reg  <= 18'(u_rem); end
                ST_PW_DIV: begin p_w_reg  <= u_quo; p_f_reg <= WIDE_W'(u_rem); end
                // For the scale divisions the remainder is below the scale, so its further
                // division by the scale is always zero and is skipped; ST_Q_DIV keeps only its quotient.
                ST_PF_DIV, ST_IB3_DIV, ST_IF3_DIV, ST_DB3_DIV, ST_Q_DIV:
                begin
                    t1_reg <= u_quo;
                end
                ST_PF_ADD: p_f_reg <= u_quo;
                ST_IA_MUL: ia_reg  <= u_quo;
                ST_IB_MUL, ST_IB2_ADD, ST_IB3_ADD: ib_reg <= u_quo;
                ST_IW_MUL: i_w_reg <= u_quo;
                ST_IF_MUL, ST_IF2_ADD, ST_IF3_ADD: i_f_reg <= u_quo;
                ST_DA_MUL, ST_NUM_MUL, ST_DB1_ADD, ST_DB2_ADD, ST_DB3_ADD:
                begin
                    num_reg <= u_quo;
                end
                ST_DQ_DIV: begin d_w_reg <= u_quo; d_f_reg <= u_rem; end
                ST_PW_MUL, ST_PF_MUL, ST_IB2_MUL, ST_IB3_MUL, ST_IF2_MUL, ST_IF3_MUL,
                ST_DB1_MUL, ST_DB2_MUL, ST_DB3_MUL, ST_NS_MUL, ST_W1_ADD, ST_W2_ADD,
                ST_W_MUL, ST_LC_ADD, ST_PF_SUM, ST_IF_SUM, ST_DF_SUM:
                begin
                    t0_reg <= u_quo;
                end
                default:
                begin
                    t0_reg <= t0_reg;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == C_IDLE);
    assign res_data = last_control_reg;

endmodule

`default_nettype wire

// File: rtl/ipid_checker.sv
// Port-level checks for the incremental PID unit, bound to the top level.
`default_nettype none

module ipid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result beat keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

    // Once a sample is taken the unit is busy and has no result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !$rose(m_axis_tvalid))
    else $error("unit not busy after taking a sample");

    // A new result only appears at the end of a computation.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while the unit was idle");

endmodule

bind incremental_pid_fixed_point_unit ipid_checker u_ipid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: test/incremental_pid_fixed_point_unit_tb.sv
// Self-checking testbench for the incremental fixed-point PID unit.
`default_nettype none

module incremental_pid_fixed_point_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ipid_pkg::*;

    localparam longint SCALE        = FRAC_SCALE_DEF;
    localparam longint CTRL_MAX     = 64'sd2147483647;
    localparam longint CTRL_MIN     = -64'sd2147483648;
    localparam int     SAMPLE_COUNT = 1450;
    localparam int     QUIET_LIMIT  = 8000;
    localparam int     DRAIN_CYCLES = 1000;

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [INDEX_W-1:0] index;
        logic [15:0]        value;   // register data or error sample
        bit                 known;   // result typed in below
        logic [31:0]        result;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;   // [15:0] error_sample
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;        // [31:0] control_value
    logic               cfg_wr_en = 1'b0;
    logic [INDEX_W-1:0] cfg_index = REG_PROP_GAIN;
    logic [GAIN_W-1:0]  cfg_wr_data = '0;

    // Mirror of the register file and of the controller history.
    logic [15:0]        kp_reg = PROP_GAIN_RST;
    logic [15:0]        ki_reg = INTEGRAL_GAIN_RST;
    logic [15:0]        kd_reg = DERIV_GAIN_RST;
    logic [15:0]        period_reg = SAMPLE_PERIOD_RST;
    logic signed [15:0] err_z1 = '0;
    logic signed [15:0] err_z2 = '0;
    logic signed [31:0] ctrl_z1 = '0;

    logic [31:0]        control_due[$];
    logic [31:0]        control_want;
    int                 errors = 0;
    int                 quiet_cycles = 0;
    int                 ready_left = 0;
    int                 n_samples = 0;
    int                 n_results = 0;
    int                 n_saturated = 0;
    int                 n_zero_period = 0;
    int                 n_writes = 0;

    incremental_pid_fixed_point_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic stim_row_t reg_row(input logic [INDEX_W-1:0] idx, input logic [15:0] val);
        return '{ROW_WRITE, idx, val, 1'b0, 32'h0};
    endfunction

    function automatic stim_row_t sample_row(input logic [15:0] e);
        return '{ROW_SAMPLE, REG_PROP_GAIN, e, 1'b0, 32'h0};
    endfunction

    function automatic stim_row_t checked_row(input logic [15:0] e, input logic [31:0] res);
        return '{ROW_SAMPLE, REG_PROP_GAIN, e, 1'b1, res};
    endfunction

    stim_row_t directed_rows [31] = '{
        // Unity proportional gain after reset: the output follows the error.
        checked_row(16'h0000, 32'h0000_0000),
        checked_row(16'h7fff, 32'h0000_7fff),
        checked_row(16'h8000, 32'hffff_8000),
        checked_row(16'h0001, 32'h0000_0001),
        checked_row(16'hffff, 32'hffff_ffff),
        // Largest derivative over the shortest period swings between the rails.
        reg_row(REG_DERIV_GAIN, 16'hffff),
        reg_row(REG_SAMPLE_PERIOD, 16'h0001),
        checked_row(16'h7fff, 32'h7fff_ffff),
        checked_row(16'h8000, 32'h8000_0000),
        sample_row(16'h8000),
        // A zero period drops the derivative term.
        reg_row(REG_SAMPLE_PERIOD, 16'h0000),
        sample_row(16'h3039),
        sample_row(16'hb1e0),
        reg_row(REG_PROP_GAIN, 16'hffff),
        reg_row(REG_INTEGRAL_GAIN, 16'hffff),
        reg_row(REG_SAMPLE_PERIOD, 16'hffff),
        sample_row(16'h7fff),
        sample_row(16'h8000),
        sample_row(16'h7fff),
        reg_row(REG_PROP_GAIN, 16'h0000),
        reg_row(REG_INTEGRAL_GAIN, 16'h0000),
        reg_row(REG_DERIV_GAIN, 16'h0000),
        sample_row(16'h0005),
        // Gains and period just off a whole unit exercise the fractional split.
        reg_row(REG_PROP_GAIN, 16'd999),
        reg_row(REG_INTEGRAL_GAIN, 16'd1),
        reg_row(REG_DERIV_GAIN, 16'd1001),
        reg_row(REG_SAMPLE_PERIOD, 16'd999),
        sample_row(16'h0309),
        sample_row(16'hfcf7),
        sample_row(16'h03e8),
        sample_row(16'hfc17)
    };

    function automatic void apply_reg(input logic [INDEX_W-1:0] idx, input logic [15:0] val);
        case (idx)
            REG_PROP_GAIN:     kp_reg = val;
            REG_INTEGRAL_GAIN: ki_reg = val;
            REG_DERIV_GAIN:    kd_reg = val;
            REG_SAMPLE_PERIOD: period_reg = val;
            default:           ;
        endcase
    endfunction

    // Velocity-form update; every partial product is split into whole and
    // fractional thousandths with truncating division.
    function automatic logic [31:0] pid_next_control(input logic signed [15:0] err_in);
        longint e, pe, ppe, last, kp, ki, kd, t;
        longint kp_w, kp_f, ki_w, ki_f, kd_w, kd_f, t_w, t_f, d1, d2;
        longint p_w, p_f, ia, ib, i_w, i_f, da, db, num, q, d_w, d_f, total;
        e    = err_in;
        pe   = err_z1;
        ppe  = err_z2;
        last = ctrl_z1;
        kp   = kp_reg;
        ki   = ki_reg;
        kd   = kd_reg;
        t    = period_reg;
        kp_w = kp / SCALE;
        kp_f = kp % SCALE;
        ki_w = ki / SCALE;
        ki_f = ki % SCALE;
        kd_w = kd / SCALE;
        kd_f = kd % SCALE;
        t_w  = t / SCALE;
        t_f  = t % SCALE;
        d1   = e - pe;
        d2   = e - 2 * pe + ppe;

        p_w = (kp_w * d1) / SCALE;
        p_f = (kp_w * d1) % SCALE + (kp_f * d1) / SCALE + ((kp_f * d1) % SCALE) / SCALE;

        ia  = ki_w * t_w;
        ib  = ki_w * t_f + ki_f * t_w + (ki_f * t_f) / SCALE;
        i_w = ia * (e / SCALE);
        i_f = ia * (e % SCALE) + ib * (e / SCALE) + (ib * (e % SCALE)) / SCALE;

        da  = kd_w * (d2 / SCALE);
        db  = kd_w * (d2 % SCALE) + kd_f * (d2 / SCALE) + (kd_f * (d2 % SCALE)) / SCALE;
        num = da * SCALE + db;
        d_w = 0;
        d_f = 0;
        if (t != 0)
        begin
            q   = (num * SCALE) / t;
            d_w = q / SCALE;
            d_f = q % SCALE;
        end

        total = last + (p_w + i_w + d_w) * SCALE + p_f + i_f + d_f;
        if (total > CTRL_MAX)
            total = CTRL_MAX;
        else if (total < CTRL_MIN)
            total = CTRL_MIN;

        err_z2  = err_z1;
        err_z1  = err_in;
        ctrl_z1 = total[31:0];
        return total[31:0];
    endfunction

    // Presents one error beat, records its expected control value on
    // acceptance, then idles for a random gap, which may be zero.
    task automatic send_error(input logic [15:0] sample, input bit known,
                              input logic [31:0] result);
        logic [31:0] predicted;
        int          gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (period_reg == 0)
            n_zero_period++;
        predicted = pid_next_control(sample);
        control_due.push_back(known ? result : predicted);
        n_samples++;
        case ($urandom_range(0, 19))
            0:                   gap = $urandom_range(200, 1200);
            1, 2, 3, 4, 5, 6, 7: gap = $urandom_range(1, 5);
            default:             gap = 0;
        endcase
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Registers change only once every control beat has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (control_due.size() != 0 || !s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        apply_reg(idx, val);
        n_writes++;
    endtask

    // Output side stalls in stretches: mostly short, some long, some none.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    m_axis_tready <= 1'b0;
                    ready_left    <= $urandom_range(50, 400);
                end
                1, 2, 3:
                begin
                    m_axis_tready <= 1'b0;
                    ready_left    <= $urandom_range(1, 4);
                end
                default:
                begin
                    m_axis_tready <= 1'b1;
                    ready_left    <= $urandom_range(1, 600);
                end
            endcase
        end
        else
        begin
            ready_left <= ready_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (m_axis_tdata == 32'h7fff_ffff || m_axis_tdata == 32'h8000_0000)
                n_saturated++;
            if (control_due.size() == 0)
            begin
                errors++;
                $display("%0t: control beat %0d arrived with none expected",
                         $time, $signed(m_axis_tdata));
            end
            else
            begin
                control_want = control_due.pop_front();
                if (m_axis_tdata !== control_want)
                begin
                    errors++;
                    $display("%0t: control_value expected %0d, got %0d", $time,
                             $signed(control_want), $signed(m_axis_tdata));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Timed out after %0d cycles without a beat", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        bit                 writing;
        int                 phase_len;
        logic [INDEX_W-1:0] idx;
        logic [15:0]        val;
        logic [15:0]        e;

        writing = 1'b0;
        e       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    wait_idle();
                    writing = 1'b1;
                end
                write_reg(directed_rows[r].index, directed_rows[r].value);
            end
            else
            begin
                if (writing)
                begin
                    cfg_wr_en <= 1'b0;
                    writing = 1'b0;
                end
                send_error(directed_rows[r].value, directed_rows[r].known,
                           directed_rows[r].result);
            end
        end

        // Random phases: new register values, then a run of samples.
        while (n_samples < SAMPLE_COUNT)
        begin
            wait_idle();
            repeat ($urandom_range(1, 4))
            begin
                idx = INDEX_W'($urandom_range(0, 3));
                case ($urandom_range(0, 7))
                    0:       val = 16'h0000;
                    1:       val = 16'hffff;
                    2:       val = 16'h0001;
                    3:       val = 16'd1000;
                    4, 5:    val = 16'($urandom_range(0, 3000));
                    default: val = 16'($urandom);
                endcase
                write_reg(idx, val);
            end
            cfg_wr_en <= 1'b0;

            phase_len = $urandom_range(10, 60);
            repeat (phase_len)
            begin
                case ($urandom_range(0, 9))
                    0:       e = 16'h7fff;
                    1:       e = 16'h8000;
                    // A slowly drifting error, as a settling loop would see.
                    2, 3, 4: e = e + 16'($urandom_range(0, 200)) - 16'd100;
                    5:       e = 16'($urandom_range(0, 4000)) - 16'd2000;
                    default: e = 16'($urandom);
                endcase
                send_error(e, 1'b0, 32'h0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (control_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d error samples (%0d with a zero period) around %0d register writes.",
                 n_samples, n_zero_period, n_writes);
        $display("Checked %0d control beats, %0d of them clamped at a rail, %0d mismatches.",
                 n_results, n_saturated, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/ipid_pkg.sv
rtl/ipid_arith.sv
rtl/ipid_ctrl.sv
rtl/incremental_pid_fixed_point_unit.sv
rtl/ipid_checker.sv
test/incremental_pid_fixed_point_unit_tb.sv
